// ===== rtl/mavg_pkg.sv =====
// Shared constants, register codes and structs for the moving-average spike alarm.
// Depends on nothing; every other file of the block but mavg_ram refers to it by scoped names.
package mavg_pkg;

    localparam int WINDOW_DEF  = 16;
    localparam int SAMPLE_W    = 12;
    localparam int MEAN_W      = 16;
    localparam int FILL_OUT_W  = 5;
    localparam int MULT_W      = 8;
    localparam int THR_W       = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_SPIKE_MUL = 2'd1;
    localparam logic [1:0] REG_MIN_MEAN  = 2'd2;

    localparam logic              ENABLED_RST   = 1'b1;
    localparam logic [MULT_W-1:0] SPIKE_MUL_RST = 8'd24;
    localparam logic [THR_W-1:0]  MIN_MEAN_RST  = 12'd100;

    typedef struct packed {
        logic              enabled;
        logic [MULT_W-1:0] spike_multiplier;
        logic [THR_W-1:0]  min_mean_threshold;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } qhead_t;

endpackage

// ===== rtl/mavg_if.sv =====
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on mavg_pkg for the field widths.
interface mavg_in_if;
    logic                          valid;
    logic                          ready;
    logic [mavg_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_out_if;
    logic                            valid;
    logic                            ready;
    logic [mavg_pkg::MEAN_W-1:0]     mean_q4;
    logic                            spike_alarm;
    logic                            warming_up;
    logic [mavg_pkg::FILL_OUT_W-1:0] fill_count;

    modport source (output valid, output mean_q4, output spike_alarm,
                    output warming_up, output fill_count, input ready);
    modport sink   (input valid, input mean_q4, input spike_alarm,
                    input warming_up, input fill_count, output ready);
endinterface

// ===== rtl/moving_average_spike_alarm_unit.sv =====
// A sample beat passes the front-end queue, then the back-end states IDLE, UPD,
// DIV (the bit-serial mean divider) and DONE, and then the result register.
// The back end takes one sample at a time and starts the next only after loading the result.
// Reset (rst_n, asynchronous, active low) clears the queue, the running total,
// the fill count, the configuration registers and the result valid flag; the ring needs no clearing pass.
module moving_average_spike_alarm_unit #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mavg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mavg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mavg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    mavg_in_if.sink                           samples,
    mavg_out_if.source                        results
);

    // Configuration registers. Software must write them only while the block is quiet, which the
    // block itself does not enforce, so the back end may read them live throughout an item's work.
    logic                          enabled_reg;
    logic [mavg_pkg::MULT_W-1:0]   spike_mul_reg;
    logic [mavg_pkg::THR_W-1:0]    min_mean_reg;
    logic                          wr_en;
    logic [1:0]                    reg_sel;
    mavg_pkg::cfg_t                cfg;
    mavg_pkg::qhead_t              head;
    logic                          pop;

    // Registers sit on 32-bit word addresses; a write to the unused fourth
    // word is simply dropped.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= mavg_pkg::ENABLED_RST;
            spike_mul_reg <= mavg_pkg::SPIKE_MUL_RST;
            min_mean_reg  <= mavg_pkg::MIN_MEAN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mavg_pkg::REG_ENABLED:   enabled_reg   <= pwdata[0];
                mavg_pkg::REG_SPIKE_MUL: spike_mul_reg <= pwdata[mavg_pkg::MULT_W-1:0];
                mavg_pkg::REG_MIN_MEAN:  min_mean_reg  <= pwdata[mavg_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mavg_pkg::REG_ENABLED:   prdata = mavg_pkg::APB_DATA_W'(enabled_reg);
            mavg_pkg::REG_SPIKE_MUL: prdata = mavg_pkg::APB_DATA_W'(spike_mul_reg);
            mavg_pkg::REG_MIN_MEAN:  prdata = mavg_pkg::APB_DATA_W'(min_mean_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.enabled            = enabled_reg;
    assign cfg.spike_multiplier   = spike_mul_reg;
    assign cfg.min_mean_threshold = min_mean_reg;

    // The front end discards every beat while disabled; otherwise it parks it in a
    // two-entry queue, stalling the input only when the queue is full, so that the input side keeps moving
    // while the back end is busy dividing.
    mavg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .enabled (enabled_reg),
        .samples (samples),
        .head    (head),
        .pop     (pop)
    );

    // The back end pulls one sample at a time: it reads the slot being
    // replaced, updates the ring and the total, runs the restoring divider one
    // quotient bit a cycle and then loads the result register. The result
    // register lets the next sample start while a result still waits.
    mavg_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

// ===== rtl/mavg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mavg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mavg_front.sv =====
// Front end: takes sample beats, drops them while disabled, queues the rest.
// Depends on mavg_pkg and the mavg_in_if interface.
module mavg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enabled,
    mavg_in_if.sink           samples,
    output mavg_pkg::qhead_t  head,
    input  logic              pop
);

    localparam int PTR_W = (mavg_pkg::QUEUE_DEPTH > 1) ? $clog2(mavg_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mavg_pkg::QUEUE_DEPTH + 1);

    logic [mavg_pkg::SAMPLE_W-1:0] slot_reg [mavg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic             push;
    logic             do_pop;

    assign full          = (count_reg == CNT_W'(mavg_pkg::QUEUE_DEPTH));
    // A disabled block still takes the beat, it simply throws it away.
    assign samples.ready = !enabled || !full;
    assign push          = samples.valid && samples.ready && enabled;
    assign do_pop        = pop && (count_reg != '0);

    assign head.valid  = (count_reg != '0);
    assign head.sample = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mavg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mavg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= samples.sample;
        end
    end

endmodule

// ===== rtl/mavg_back.sv =====
// Back end: ring update, running total, bit-serial mean divider, alarm test
// and the result register. Depends on mavg_pkg, mavg_out_if and mavg_ram.
module mavg_back #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mavg_pkg::cfg_t   cfg,
    input  mavg_pkg::qhead_t head,
    output logic             pop,
    mavg_out_if.source       results
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int TOT_W  = mavg_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int NUM_W  = TOT_W + 4;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int CMP_W  = TOT_W + mavg_pkg::MULT_W;
    localparam logic [CMP_W-1:0] LHS_K = CMP_W'(16 * WINDOW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic [FILL_W-1:0]             filled_reg, filled_next;
    logic [TOT_W-1:0]              total_reg, total_next;
    logic [mavg_pkg::SAMPLE_W-1:0] samp_reg, samp_next;
    logic [FILL_W-1:0]             rem_reg, rem_next;
    logic [NUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CMP_W-1:0]              prod_reg, prod_next;

    logic                              out_valid_reg, out_valid_next;
    logic [mavg_pkg::MEAN_W-1:0]       mean_reg, mean_next;
    logic                              alarm_reg, alarm_next;
    logic                              warm_reg, warm_next;
    logic [mavg_pkg::FILL_OUT_W-1:0]   fill_reg, fill_next;

    logic                          ram_we;
    logic [mavg_pkg::SAMPLE_W-1:0] ram_rdata;
    logic [mavg_pkg::SAMPLE_W-1:0] old_sample;
    logic                          full;
    logic [FILL_W:0]               trial;
    logic                          trial_ge;
    logic                          load_out;
    logic [CMP_W-1:0]              lhs;
    logic [CMP_W-1:0]              floor_sum;

    mavg_ram #(
        .WIDTH (mavg_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (samp_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Entries are overwritten in ring order, so until the window is full the
    // slot being replaced has never been written, so old_sample takes zero in its place.
    assign full       = (filled_reg == FILL_W'(WINDOW));
    assign old_sample = full ? ram_rdata : '0;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, filled_reg});
    assign lhs       = CMP_W'(samp_reg) * LHS_K;
    assign floor_sum = CMP_W'(cfg.min_mean_threshold) * CMP_W'(WINDOW);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);
    assign pop       = (state_reg == ST_IDLE) && head.valid;

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        filled_next = filled_reg;
        total_next  = total_reg;
        samp_next   = samp_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        ram_we      = 1'b0;
        mean_next   = mean_reg;
        alarm_next  = alarm_reg;
        warm_next   = warm_reg;
        fill_next   = fill_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    samp_next  = head.sample;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                ram_we      = 1'b1;
                total_next  = total_reg - TOT_W'(old_sample) + TOT_W'(samp_reg);
                slot_next   = (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                filled_next = full ? filled_reg : filled_reg + 1'b1;
                quo_next    = {total_next, 4'b0000};
                rem_next    = '0;
                cnt_next    = CNT_W'(NUM_W);
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                prod_next = CMP_W'(total_reg) * CMP_W'(cfg.spike_multiplier);
                rem_next  = trial_ge ? FILL_W'(trial - {1'b0, filled_reg}) : FILL_W'(trial);
                quo_next  = {quo_reg[NUM_W-2:0], trial_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    mean_next  = mavg_pkg::MEAN_W'(quo_reg);
                    alarm_next = full && (lhs > prod_reg)
                                 && (CMP_W'(total_reg) > floor_sum);
                    warm_next  = !full;
                    fill_next  = mavg_pkg::FILL_OUT_W'(filled_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            filled_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            filled_reg    <= filled_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg  <= samp_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        mean_reg  <= mean_next;
        alarm_reg <= alarm_next;
        warm_reg  <= warm_next;
        fill_reg  <= fill_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.mean_q4     = mean_reg;
    assign results.spike_alarm = alarm_reg;
    assign results.warming_up  = warm_reg;
    assign results.fill_count  = fill_reg;

endmodule

// ===== rtl/mavg_chk.sv =====
// Port-level checks on the moving-average spike alarm, bound to the top level.
// Depends on mavg_pkg and on moving_average_spike_alarm_unit.
module mavg_chk #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [mavg_pkg::MEAN_W-1:0]     mean_q4,
    input logic                            spike_alarm,
    input logic                            warming_up,
    input logic [mavg_pkg::FILL_OUT_W-1:0] fill_count
);

    // A result that is not taken must hold still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mean_q4)
        && $stable(spike_alarm) && $stable(fill_count))
        else $error("result changed while stalled");

    // The alarm needs a full window.
    a_alarm_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && spike_alarm |-> !warming_up)
        else $error("alarm raised during warm-up");

    // A mean is never above the largest sample in Q12.4.
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> mean_q4 <= 16'd65520)
        else $error("mean out of range");

    // During warm-up the window holds at least the current sample.
    a_warm_fill: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && warming_up |-> (WINDOW > 31) || (fill_count != '0))
        else $error("warm-up result with empty window");

endmodule

bind moving_average_spike_alarm_unit mavg_chk #(
    .WINDOW (WINDOW)
) u_mavg_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .mean_q4     (results.mean_q4),
    .spike_alarm (results.spike_alarm),
    .warming_up  (results.warming_up),
    .fill_count  (results.fill_count)
);
